// ----- rtl/joystick_event_generator_core_macros.svh -----
// Assertion macros for the joystick event generator core.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef JOYSTICK_EVENT_GENERATOR_CORE_MACROS_SVH
`define JOYSTICK_EVENT_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define JEG_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define JEG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/jeg_pkg.sv -----
// Shared types and constants of the joystick event generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jeg_pkg;

    localparam int AXIS_W     = 16;
    localparam int DZ_W       = 13;
    localparam int BUTTON_W   = 16;
    localparam int BTN_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int JOB_Q_DEPTH = 2;
    localparam int JOB_Q_PTR_W = $clog2(JOB_Q_DEPTH);

    localparam logic [AXIS_W-1:0] HAT_CENTERED   = 16'hFFFF;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST  = 13'd512;
    localparam logic [AXIS_W-1:0] CENTER_RST     = 16'd8191;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 2'd1;

    typedef enum logic [1:0] {
        EV_CONN   = 2'd0,
        EV_POS    = 2'd1,
        EV_HAT    = 2'd2,
        EV_BUTTON = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic [DZ_W-1:0]   dead_zone;
        logic [AXIS_W-1:0] center;
    } cfg_t;

    // One poll's worth of pending events, as handed from front to back.
    typedef struct packed {
        logic                conn;
        logic                conn_val;
        logic                pos;
        logic                moving;
        logic [AXIS_W-1:0]   x;
        logic [AXIS_W-1:0]   y;
        logic [AXIS_W-1:0]   z;
        logic                hat;
        logic                hat_act;
        logic [BUTTON_W-1:0] btn_mask;
        logic [BUTTON_W-1:0] btn_new;
    } job_t;

    typedef struct packed {
        ev_kind_t             kind;
        logic                 connected;
        logic                 moving;
        logic [AXIS_W-1:0]    x;
        logic [AXIS_W-1:0]    y;
        logic [AXIS_W-1:0]    z;
        logic                 hat_active;
        logic [BTN_IDX_W-1:0] button_index;
        logic                 button_pressed;
        logic                 last;
    } event_t;

endpackage

// ----- rtl/jeg_front.sv -----
// Front end: accepts polls, compares them with the held device state and
// queues a request of pending events. Depends on jeg_pkg.
`timescale 1ns / 1ps

module jeg_front #(
    parameter int BUTTON_COUNT = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  jeg_pkg::cfg_t                cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_read_ok,
    input  logic [jeg_pkg::AXIS_W-1:0]   s_x_pos,
    input  logic [jeg_pkg::AXIS_W-1:0]   s_y_pos,
    input  logic [jeg_pkg::AXIS_W-1:0]   s_z_pos,
    input  logic [jeg_pkg::AXIS_W-1:0]   s_hat_value,
    input  logic [jeg_pkg::BUTTON_W-1:0] s_button_bits,
    input  logic                         q_full,
    output logic                         q_push,
    output jeg_pkg::job_t                q_job
);
    import jeg_pkg::*;

    localparam int BTN_EXAM = (BUTTON_COUNT < BUTTON_W) ? BUTTON_COUNT : BUTTON_W;

    logic                link_reg, link_next;
    logic                move_reg, move_next;
    logic [AXIS_W-1:0]   held_x_reg, held_x_next;
    logic [AXIS_W-1:0]   held_y_reg, held_y_next;
    logic [AXIS_W-1:0]   held_z_reg, held_z_next;
    logic [AXIS_W-1:0]   prev_hat_reg, prev_hat_next;
    logic [BUTTON_W-1:0] prev_btn_reg, prev_btn_next;
    logic [BUTTON_W-1:0] exam_mask;
    logic                accept, xm, ym;
    job_t                job;

    function automatic logic axis_moves(input logic [AXIS_W-1:0] v,
                                        input logic [AXIS_W-1:0] c,
                                        input logic [DZ_W-1:0]   dz);
        logic [AXIS_W-1:0] d;
        d = (v >= c) ? (v - c) : (c - v);
        return d > {{(AXIS_W-DZ_W){1'b0}}, dz};
    endfunction

    always_comb begin
        for (int i = 0; i < BUTTON_W; i++) begin
            exam_mask[i] = (i < BTN_EXAM);
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign xm      = axis_moves(s_x_pos, cfg.center, cfg.dead_zone);
    assign ym      = axis_moves(s_y_pos, cfg.center, cfg.dead_zone);

    always_comb begin
        link_next     = link_reg;
        move_next     = move_reg;
        held_x_next   = held_x_reg;
        held_y_next   = held_y_reg;
        held_z_next   = held_z_reg;
        prev_hat_next = prev_hat_reg;
        prev_btn_next = prev_btn_reg;
        job           = '0;
        if (accept) begin
            if (!s_read_ok) begin
                if (link_reg) begin
                    link_next    = 1'b0;
                    job.conn     = 1'b1;
                    job.conn_val = 1'b0;
                end
            end else begin
                if (!link_reg) begin
                    link_next    = 1'b1;
                    job.conn     = 1'b1;
                    job.conn_val = 1'b1;
                end
                if (xm || ym) begin
                    move_next   = 1'b1;
                    held_x_next = xm ? s_x_pos : cfg.center;
                    held_y_next = ym ? s_y_pos : cfg.center;
                    held_z_next = s_z_pos;
                    job.pos     = 1'b1;
                    job.moving  = 1'b1;
                    job.x       = held_x_next;
                    job.y       = held_y_next;
                    job.z       = held_z_next;
                end else if (move_reg) begin
                    // report the stop at the last held position
                    move_next  = 1'b0;
                    job.pos    = 1'b1;
                    job.moving = 1'b0;
                    job.x      = held_x_reg;
                    job.y      = held_y_reg;
                    job.z      = held_z_reg;
                end
                if (s_hat_value != prev_hat_reg) begin
                    job.hat       = 1'b1;
                    job.hat_act   = (s_hat_value != HAT_CENTERED);
                    prev_hat_next = s_hat_value;
                end
                job.btn_mask  = (prev_btn_reg ^ s_button_bits) & exam_mask;
                job.btn_new   = s_button_bits;
                prev_btn_next = s_button_bits;
            end
        end
    end

    // drop polls that cause no event
    assign q_push = accept && (job.conn || job.pos || job.hat || (|job.btn_mask));
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg     <= 1'b0;
            move_reg     <= 1'b0;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            held_z_reg   <= '0;
            prev_hat_reg <= HAT_CENTERED;
            prev_btn_reg <= '0;
        end else begin
            link_reg     <= link_next;
            move_reg     <= move_next;
            held_x_reg   <= held_x_next;
            held_y_reg   <= held_y_next;
            held_z_reg   <= held_z_next;
            prev_hat_reg <= prev_hat_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

endmodule

// ----- rtl/jeg_fifo.sv -----
// Short request queue between the front and back ends.
// Depends on jeg_pkg for the request type and depth.
`timescale 1ns / 1ps

module jeg_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jeg_pkg::job_t push_job,
    input  logic          pop,
    output jeg_pkg::job_t pop_job,
    output logic          full,
    output logic          empty
);
    import jeg_pkg::*;

    localparam logic [JOB_Q_PTR_W:0] DEPTH_CNT = (JOB_Q_PTR_W+1)'(JOB_Q_DEPTH);
    localparam logic [JOB_Q_PTR_W-1:0] LAST_PTR = JOB_Q_PTR_W'(JOB_Q_DEPTH - 1);

    job_t                   entry_reg [JOB_Q_DEPTH];
    logic [JOB_Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_Q_PTR_W:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/jeg_back.sv -----
// Back end: takes one queued request at a time and serializes its events
// into the output register, one per cycle while m_ready holds. Depends on jeg_pkg.
`timescale 1ns / 1ps

module jeg_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  jeg_pkg::job_t    q_job,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output jeg_pkg::event_t  m_event
);
    import jeg_pkg::*;

    job_t                 job_reg, job_next;
    logic                 job_valid_reg, job_valid_next;
    event_t               ev_reg, ev_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 emit;
    logic [BTN_IDX_W-1:0] low_idx;
    logic [BUTTON_W-1:0]  mask_rest;
    job_t                 rest;

    // lowest pending button edge
    always_comb begin
        low_idx = '0;
        for (int i = BUTTON_W - 1; i >= 0; i--) begin
            if (job_reg.btn_mask[i]) begin
                low_idx = BTN_IDX_W'(i);
            end
        end
    end

    assign mask_rest = job_reg.btn_mask & (job_reg.btn_mask - 1'b1);
    assign emit      = job_valid_reg && (!out_valid_reg || m_ready);
    assign q_pop     = !job_valid_reg && !q_empty;

    always_comb begin
        ev_next        = ev_reg;
        out_valid_next = out_valid_reg;
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        rest           = job_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (q_pop) begin
            job_next       = q_job;
            job_valid_next = 1'b1;
        end else if (emit) begin
            ev_next = '0;
            if (job_reg.conn) begin
                ev_next.kind      = EV_CONN;
                ev_next.connected = job_reg.conn_val;
                rest.conn         = 1'b0;
            end else if (job_reg.pos) begin
                ev_next.kind   = EV_POS;
                ev_next.moving = job_reg.moving;
                ev_next.x      = job_reg.x;
                ev_next.y      = job_reg.y;
                ev_next.z      = job_reg.z;
                rest.pos       = 1'b0;
            end else if (job_reg.hat) begin
                ev_next.kind       = EV_HAT;
                ev_next.hat_active = job_reg.hat_act;
                rest.hat           = 1'b0;
            end else begin
                ev_next.kind           = EV_BUTTON;
                ev_next.button_index   = low_idx;
                ev_next.button_pressed = job_reg.btn_new[low_idx];
                rest.btn_mask          = mask_rest;
            end
            ev_next.last   = !(rest.conn || rest.pos || rest.hat || (|rest.btn_mask));
            out_valid_next = 1'b1;
            job_next       = rest;
            job_valid_next = !ev_next.last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_event = ev_reg;

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        ev_reg  <= ev_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/joystick_event_generator_core.sv -----
// Joystick event generator: one poll in, up to 19 events out, one event per cycle while m_ready holds.
// The first event passes through the request queue, then the back end's request register, then the output register.
// The back end takes a new request only once the last event of the one it holds is emitted;
// the two-entry request queue lets the front take polls while events drain.
// Reset: synchronous, active low; link down, hat centered, buttons released,
// dead zone 512, center 8191, queue empty.
`timescale 1ns / 1ps

module joystick_event_generator_core #(
    parameter int BUTTON_COUNT = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jeg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jeg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_read_ok,
    input  logic [jeg_pkg::AXIS_W-1:0]     s_x_pos,
    input  logic [jeg_pkg::AXIS_W-1:0]     s_y_pos,
    input  logic [jeg_pkg::AXIS_W-1:0]     s_z_pos,
    input  logic [jeg_pkg::AXIS_W-1:0]     s_hat_value,
    input  logic [jeg_pkg::BUTTON_W-1:0]   s_button_bits,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_event_kind,
    output logic                           m_connected,
    output logic                           m_moving,
    output logic [jeg_pkg::AXIS_W-1:0]     m_x_out,
    output logic [jeg_pkg::AXIS_W-1:0]     m_y_out,
    output logic [jeg_pkg::AXIS_W-1:0]     m_z_out,
    output logic                           m_hat_active,
    output logic [jeg_pkg::BTN_IDX_W-1:0]  m_button_index,
    output logic                           m_button_pressed,
    output logic                           m_last_of_run
);
    import jeg_pkg::*;

    `include "joystick_event_generator_core_macros.svh"

    localparam int BTN_EXAM = (BUTTON_COUNT < BUTTON_W) ? BUTTON_COUNT : BUTTON_W;

    cfg_t   cfg_reg, cfg_next;
    logic   q_push, q_pop, q_full, q_empty;
    job_t   push_job, pop_job;
    event_t ev;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEAD_ZONE: cfg_next.dead_zone = cfg_data[DZ_W-1:0];
                REG_CENTER:    cfg_next.center    = cfg_data[AXIS_W-1:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dead_zone <= DEAD_ZONE_RST;
            cfg_reg.center    <= CENTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    jeg_front #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_read_ok    (s_read_ok),
        .s_x_pos      (s_x_pos),
        .s_y_pos      (s_y_pos),
        .s_z_pos      (s_z_pos),
        .s_hat_value  (s_hat_value),
        .s_button_bits(s_button_bits),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    jeg_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_job(push_job),
        .pop     (q_pop),
        .pop_job (pop_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    jeg_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_job  (pop_job),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_event(ev)
    );

    assign m_event_kind     = ev.kind;
    assign m_connected      = ev.connected;
    assign m_moving         = ev.moving;
    assign m_x_out          = ev.x;
    assign m_y_out          = ev.y;
    assign m_z_out          = ev.z;
    assign m_hat_active     = ev.hat_active;
    assign m_button_index   = ev.button_index;
    assign m_button_pressed = ev.button_pressed;
    assign m_last_of_run    = ev.last;

    `JEG_ASSERT_NOW(a_button_fields_clear, aclk, aresetn,
        m_valid && (m_event_kind == EV_BUTTON),
        (m_x_out == '0) && (m_y_out == '0) && (m_z_out == '0) && !m_connected,
        "button event carries position or link fields")
    `JEG_ASSERT_NOW(a_button_index_range, aclk, aresetn,
        m_valid && (m_event_kind == EV_BUTTON),
        {1'b0, m_button_index} < (BTN_IDX_W+1)'(BTN_EXAM),
        "button event index beyond examined buttons")
    `JEG_ASSERT_NEXT(a_run_streams, aclk, aresetn,
        m_valid && m_ready && !m_last_of_run,
        m_valid,
        "event run broken before its last event")
    `JEG_ASSERT_NOW(a_push_has_room, aclk, aresetn,
        q_push,
        !q_full,
        "request pushed into a full queue")

endmodule

// ----- tb/sv/joystick_event_generator_core_tb.sv -----
// Self-checking testbench for joystick_event_generator_core: drives polls and
// register writes, predicts the event stream and checks every event by field.
// Depends on jeg_pkg and the core RTL only.
`timescale 1ns / 1ps

module joystick_event_generator_core_tb;
    import jeg_pkg::*;

    localparam int BUTTONS    = 16;
    localparam int MAX_EVENTS = 19;
    localparam int WATCHDOG   = 400000;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic                read_ok;
        logic [AXIS_W-1:0]   x;
        logic [AXIS_W-1:0]   y;
        logic [AXIS_W-1:0]   z;
        logic [AXIS_W-1:0]   hat;
        logic [BUTTON_W-1:0] buttons;
    } poll_t;

    typedef struct packed {
        ev_kind_t             kind;
        logic                 connected;
        logic                 moving;
        logic [AXIS_W-1:0]    x;
        logic [AXIS_W-1:0]    y;
        logic [AXIS_W-1:0]    z;
        logic                 hat_active;
        logic [BTN_IDX_W-1:0] button_index;
        logic                 button_pressed;
        logic                 last_of_run;
    } joy_event_t;

    // Tracks link, movement, hat and button state; queues the events each poll causes.
    class joystick_predictor;
        logic [DZ_W-1:0]     dead_zone = DEAD_ZONE_RST;
        logic [AXIS_W-1:0]   center = CENTER_RST;
        logic                link_up = 1'b0;
        logic                move_active = 1'b0;
        logic [AXIS_W-1:0]   held_x = '0;
        logic [AXIS_W-1:0]   held_y = '0;
        logic [AXIS_W-1:0]   held_z = '0;
        logic [AXIS_W-1:0]   last_hat = HAT_CENTERED;
        logic [BUTTON_W-1:0] last_buttons = '0;
        joy_event_t          expected_events[$];
        int                  mismatches = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEAD_ZONE: dead_zone = data[DZ_W-1:0];
                REG_CENTER:    center = data;
                default: ;
            endcase
        endfunction

        function bit beyond_zone(logic [AXIS_W-1:0] v);
            logic [AXIS_W-1:0] span;
            span = (v >= center) ? v - center : center - v;
            return span > {{(AXIS_W-DZ_W){1'b0}}, dead_zone};
        endfunction

        function void take_poll(poll_t p);
            joy_event_t run[$];
            joy_event_t e;
            bit         xm;
            bit         ym;
            if (!p.read_ok) begin
                // a failed poll only reports the link drop
                if (link_up) begin
                    link_up = 1'b0;
                    e = '0;
                    e.kind = EV_CONN;
                    run.push_back(e);
                end
            end else begin
                if (!link_up) begin
                    link_up = 1'b1;
                    e = '0;
                    e.kind = EV_CONN;
                    e.connected = 1'b1;
                    run.push_back(e);
                end
                xm = beyond_zone(p.x);
                ym = beyond_zone(p.y);
                if (xm || ym) begin
                    move_active = 1'b1;
                    held_x = xm ? p.x : center;
                    held_y = ym ? p.y : center;
                    held_z = p.z;
                end
                if (xm || ym || move_active) begin
                    e = '0;
                    e.kind = EV_POS;
                    e.moving = xm || ym;
                    e.x = held_x;
                    e.y = held_y;
                    e.z = held_z;
                    run.push_back(e);
                    if (!(xm || ym)) move_active = 1'b0;
                end
                if (p.hat != last_hat) begin
                    e = '0;
                    e.kind = EV_HAT;
                    e.hat_active = (p.hat != HAT_CENTERED);
                    last_hat = p.hat;
                    run.push_back(e);
                end
                for (int i = 0; i < BUTTONS && i < BUTTON_W; i++) begin
                    if (p.buttons[i] != last_buttons[i] && run.size() < MAX_EVENTS) begin
                        e = '0;
                        e.kind = EV_BUTTON;
                        e.button_index = i[BTN_IDX_W-1:0];
                        e.button_pressed = p.buttons[i];
                        run.push_back(e);
                    end
                end
                last_buttons = p.buttons;
            end
            if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
            foreach (run[k]) expected_events.push_back(run[k]);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_event(joy_event_t got);
            joy_event_t want;
            if (expected_events.size() == 0) begin
                $error("event_kind: expected no event, got %0d", got.kind);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_kind", want.kind, got.kind);
            compare_field("connected", want.connected, got.connected);
            compare_field("moving", want.moving, got.moving);
            compare_field("x_out", want.x, got.x);
            compare_field("y_out", want.y, got.y);
            compare_field("z_out", want.z, got.z);
            compare_field("hat_active", want.hat_active, got.hat_active);
            compare_field("button_index", want.button_index, got.button_index);
            compare_field("button_pressed", want.button_pressed, got.button_pressed);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_read_ok = 1'b0;
    logic [AXIS_W-1:0]     s_x_pos = '0;
    logic [AXIS_W-1:0]     s_y_pos = '0;
    logic [AXIS_W-1:0]     s_z_pos = '0;
    logic [AXIS_W-1:0]     s_hat_value = '0;
    logic [BUTTON_W-1:0]   s_button_bits = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_event_kind;
    logic                  m_connected;
    logic                  m_moving;
    logic [AXIS_W-1:0]     m_x_out;
    logic [AXIS_W-1:0]     m_y_out;
    logic [AXIS_W-1:0]     m_z_out;
    logic                  m_hat_active;
    logic [BTN_IDX_W-1:0]  m_button_index;
    logic                  m_button_pressed;
    logic                  m_last_of_run;

    joystick_predictor board;
    int                send_idle_pct = 31;
    int                recv_idle_pct = 72;

    joystick_event_generator_core #(
        .BUTTON_COUNT(BUTTONS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_read_ok       (s_read_ok),
        .s_x_pos         (s_x_pos),
        .s_y_pos         (s_y_pos),
        .s_z_pos         (s_z_pos),
        .s_hat_value     (s_hat_value),
        .s_button_bits   (s_button_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_connected     (m_connected),
        .m_moving        (m_moving),
        .m_x_out         (m_x_out),
        .m_y_out         (m_y_out),
        .m_z_out         (m_z_out),
        .m_hat_active    (m_hat_active),
        .m_button_index  (m_button_index),
        .m_button_pressed(m_button_pressed),
        .m_last_of_run   (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    // Sample the result channel and randomize the receiver's stalls.
    always @(posedge aclk) begin : event_monitor
        joy_event_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind = ev_kind_t'(m_event_kind);
            got.connected = m_connected;
            got.moving = m_moving;
            got.x = m_x_out;
            got.y = m_y_out;
            got.z = m_z_out;
            got.hat_active = m_hat_active;
            got.button_index = m_button_index;
            got.button_pressed = m_button_pressed;
            got.last_of_run = m_last_of_run;
            board.check_event(got);
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic poll_t mk_poll(logic ok, logic [15:0] x, logic [15:0] y,
                                      logic [15:0] z, logic [15:0] hat, logic [15:0] btn);
        poll_t p;
        p.read_ok = ok;
        p.x = x;
        p.y = y;
        p.z = z;
        p.hat = hat;
        p.buttons = btn;
        return p;
    endfunction

    function automatic logic [AXIS_W-1:0] pick_axis(int c, int dz, bit rest);
        int v;
        case (rest ? 0 : $urandom_range(5))
            0: v = c - dz + int'($urandom_range(2 * dz));
            1: v = $urandom_range(1) ? c + dz + int'($urandom_range(1))
                                     : c - dz - int'($urandom_range(1));
            2: v = int'($urandom_range(16'hFFFF));
            3: v = $urandom_range(1) ? 16'hFFFF : 0;
            default: v = $urandom_range(1) ? c + dz + 1 + int'($urandom_range(3000))
                                           : c - dz - 1 - int'($urandom_range(3000));
        endcase
        if (v < 0) v = 0;
        if (v > 16'hFFFF) v = 16'hFFFF;
        return v[AXIS_W-1:0];
    endfunction

    function automatic poll_t random_poll();
        poll_t p;
        bit    rest;
        int    c;
        int    dz;
        c = int'(board.center);
        dz = int'(board.dead_zone);
        // bias toward rest so that stop events show up
        rest = ($urandom_range(99) < 30);
        p.read_ok = ($urandom_range(99) >= 8);
        p.x = pick_axis(c, dz, rest);
        p.y = pick_axis(c, dz, rest);
        p.z = AXIS_W'($urandom_range(16'hFFFF));
        case ($urandom_range(9))
            0, 1, 2, 3, 4: p.hat = board.last_hat;
            5, 6:          p.hat = HAT_CENTERED;
            7, 8:          p.hat = AXIS_W'($urandom_range(7));
            default:       p.hat = AXIS_W'($urandom_range(16'hFFFF));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: p.buttons = board.last_buttons ^ (16'h1 << $urandom_range(15))
                                       ^ ($urandom_range(1) ? 16'h1 << $urandom_range(15) : 16'h0);
            5:             p.buttons = board.last_buttons;
            6, 7:          p.buttons = BUTTON_W'($urandom_range(16'hFFFF));
            8:             p.buttons = 16'hFFFF;
            default:       p.buttons = 16'h0000;
        endcase
        return p;
    endfunction

    // Hold valid across back-to-back requests; drop it only for a gap.
    task automatic drive_poll(poll_t p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_read_ok <= p.read_ok;
        s_x_pos <= p.x;
        s_y_pos <= p.y;
        s_z_pos <= p.z;
        s_hat_value <= p.hat;
        s_button_bits <= p.buttons;
        do @(posedge aclk); while (!s_ready);
        board.take_poll(p);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait out every pending event, then let the core settle.
    task automatic drain_events();
        s_valid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < WATCHDOG) begin
            @(posedge aclk);
            cycles++;
        end
        $display("joystick_event_generator_core_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] c;
        logic [15:0] dz_word;
        logic [15:0] c_word;
        board = new();
        c = CENTER_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: link changes, zone edges, stop, hat, full button sweeps
        drive_poll(mk_poll(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
        drive_poll(mk_poll(1'b1, c, c, 16'd0, HAT_CENTERED, 16'h0000));
        drive_poll(mk_poll(1'b1, c + DEAD_ZONE_RST, c - DEAD_ZONE_RST, 16'd100,
                           HAT_CENTERED, 16'h0000));
        drive_poll(mk_poll(1'b1, c + DEAD_ZONE_RST + 1, c, 16'd200, HAT_CENTERED, 16'h0000));
        drive_poll(mk_poll(1'b1, c, c - DEAD_ZONE_RST - 1, 16'd300, HAT_CENTERED, 16'h0000));
        drive_poll(mk_poll(1'b1, c, c, 16'd400, HAT_CENTERED, 16'h0000));
        drive_poll(mk_poll(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        drive_poll(mk_poll(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        drive_poll(mk_poll(1'b1, c, c, 16'h5555, 16'h0007, 16'h0000));
        drive_poll(mk_poll(1'b1, c, c, 16'hAAAA, HAT_CENTERED, 16'hFFFF));
        drive_poll(mk_poll(1'b1, c, c, 16'd1, HAT_CENTERED, 16'h0000));
        drive_poll(mk_poll(1'b1, c, c, 16'd2, HAT_CENTERED, 16'h0001));
        drive_poll(mk_poll(1'b1, c, c, 16'd3, HAT_CENTERED, 16'h8000));
        drive_poll(mk_poll(1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'h0001, 16'h0F0F));
        drive_poll(mk_poll(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'hF0F0));
        drive_poll(mk_poll(1'b1, 16'h0000, 16'h0000, 16'hABCD, 16'h0003, 16'h7FFF));
        drive_poll(mk_poll(1'b1, c, c, 16'd7, HAT_CENTERED, 16'h8000));
        drive_poll(mk_poll(1'b0, c, c, 16'd8, HAT_CENTERED, 16'h8000));
        drive_poll(mk_poll(1'b1, c, c, 16'd9, HAT_CENTERED, 16'h8000));
        drive_poll(mk_poll(1'b1, c, c, 16'd5, HAT_CENTERED, 16'h8000));

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 72 : 0;
            recv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 31 : 0;
            if (ph > 0) begin
                case (ph)
                    1: begin
                        dz_word = 16'h0000;
                        c_word = 16'h0000;
                    end
                    2: begin
                        // upper dead-zone bits fall outside the register
                        dz_word = 16'hFFFF;
                        c_word = 16'hFFFF;
                    end
                    3: begin
                        dz_word = 16'($urandom_range(2047));
                        c_word = 16'($urandom_range(16'hFFFF));
                    end
                    4: begin
                        dz_word = 16'($urandom_range(16'hFFFF));
                        c_word = 16'($urandom_range(16'hFFFF));
                    end
                    default: begin
                        dz_word = 16'($urandom_range(255));
                        c_word = 16'($urandom_range(16'hFFFF));
                    end
                endcase
                write_reg(REG_DEAD_ZONE, dz_word);
                write_reg(REG_CENTER, c_word);
            end
            repeat (35) drive_poll(random_poll());
            drain_events();
        end

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("joystick_event_generator_core_tb: done, clean");
        end else begin
            $display("joystick_event_generator_core_tb: done, errors");
        end
        $finish;
    end

endmodule
